@@ design/ils_pkg.sv @@
// Shared constants, codes and types for the indexed list store.
package ils_pkg;

   // Fixed field widths of the two streams.
   localparam int CMD_W       = 3;
   localparam int INDEX_W     = 5;
   localparam int VALUE_W     = 32;
   localparam int FIDX_W      = 4;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 5;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 48;

   // Position bus to the cells, wide enough for the largest supported depth.
   localparam int POS_W       = 8;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WIDTH_DEFAULT = 32;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PREPEND = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd6;
   localparam logic [CMD_W-1:0] CMD_FIND    = 3'd7;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   // Cell operations.
   localparam logic [1:0] CELL_HOLD = 2'd0;
   localparam logic [1:0] CELL_INS  = 2'd1;
   localparam logic [1:0] CELL_DEL  = 2'd2;

   // Control broadcast along the cell row.
   typedef struct packed {
      logic [1:0]       op;
      logic [POS_W-1:0] pos;
   } cell_ctrl_type;

   // Result transaction, lowest field in the lowest bits.
   typedef struct packed {
      logic [2:0]          pad;
      logic                empty_res;
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
      logic [FIDX_W-1:0]   found_index;
      logic                found;
      logic [VALUE_W-1:0]  data;
   } rsp_type;

endpackage

@@ design/ils_cell.sv @@
// One storage cell of the list: holds a word and moves it up or down the row.
module ils_cell
   import ils_pkg::*;
#(
   parameter int WIDTH = WIDTH_DEFAULT,
   parameter int INDEX = 0
) (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [WIDTH-1:0]    new_word,
   input  logic [WIDTH-1:0]    lower_word,
   input  logic [WIDTH-1:0]    upper_word,
   output logic [WIDTH-1:0]    word
);

   localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

   logic [WIDTH-1:0] word_ff;
   logic [WIDTH-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      case (ctrl.op)
         CELL_INS: begin
            // Cells above the gap take their lower neighbor's word.
            if (ctrl.pos == MY_POS) begin
               word_in = new_word;
            end else if (ctrl.pos < MY_POS) begin
               word_in = lower_word;
            end
         end
         CELL_DEL: begin
            if (ctrl.pos <= MY_POS) begin
               word_in = upper_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

@@ design/ils_chain.sv @@
// Row of list cells with neighbor links and a single indexed read port.
module ils_chain
   import ils_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int WIDTH = WIDTH_DEFAULT,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [WIDTH-1:0]  new_word,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [WIDTH-1:0]  rd_word
);

   logic [WIDTH-1:0] words [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WIDTH-1:0] lower;
      logic [WIDTH-1:0] upper;

      if (i == 0) begin : g_first
         assign lower = '0;
      end else begin : g_mid_lo
         assign lower = words[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign upper = words[i];
      end else begin : g_mid_hi
         assign upper = words[i+1];
      end

      ils_cell #(
         .WIDTH (WIDTH),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .new_word   (new_word),
         .lower_word (lower),
         .upper_word (upper),
         .word       (words[i])
      );
   end

   assign rd_word = words[rd_addr];

endmodule

@@ design/indexed_list_store.sv @@
// Top level of the indexed list store: command decode, scan sequencer, result register.
//
// Commands arrive on the req_ stream (kind in req_tuser, index and value in
// req_tdata) and each produces exactly one result transaction on rsp_. The
// list lives in a row of DEPTH cells; insert and delete shift every cell
// above the position at once, so push, insert, prepend, pop, read and
// delete finish in the accepting cycle and their result is valid on the
// next clock. Remove-all and find walk the list with one read port, one
// position per cycle; remove-all deletes each matching entry in place and
// ends when the position reaches the entry count, find ends there or at
// the first match, and no request is accepted until the walk has ended.
// The result sits in an output register; a new request is accepted while
// that register is empty or is being emptied in the same cycle, so a
// stalled receiver holds off further requests without losing anything.
// Reset empties the list (count zero) and drops any pending result; cell
// contents are not cleared since only entries below the count are read.
module indexed_list_store
   import ils_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int WIDTH = WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,  // index[4:0], value[36:5], zero pad
   input  logic [CMD_W-1:0]       req_tuser,  // cmd[2:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata   // data[31:0], found[32], found_index[36:33],
                                              // status[38:37], count[43:39],
                                              // empty_res[44], zero pad
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                state_ff,     state_in;
   logic [CNT_W-1:0]    count_ff,     count_in;
   logic [CNT_W-1:0]    ptr_ff,       ptr_in;
   logic                find_ff,      find_in;
   logic [WIDTH-1:0]    val_ff,       val_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff,       rsp_in;

   logic [CMD_W-1:0]    req_cmd;
   logic [INDEX_W-1:0]  req_index;
   logic [VALUE_W-1:0]  req_value;
   logic [WIDTH-1:0]    req_word;
   logic                req_fire;

   cell_ctrl_type       cell_ctrl;
   logic [IDX_W-1:0]    rd_addr;
   logic [WIDTH-1:0]    rd_word;

   logic [CMP_W-1:0]    idx_ext;
   logic [CMP_W-1:0]    cnt_ext;
   logic [CNT_W-1:0]    cnt_dec;
   logic                full;
   logic                finish;
   logic                found;
   logic [STATUS_W-1:0] status;
   logic [WIDTH-1:0]    out_word;

   assign req_cmd   = req_tuser;
   assign req_index = req_tdata[INDEX_W-1:0];
   assign req_value = req_tdata[INDEX_W +: VALUE_W];
   assign req_word  = WIDTH'(signed'(req_value));

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   assign idx_ext = CMP_W'(req_index);
   assign cnt_ext = CMP_W'(count_ff);
   assign cnt_dec = count_ff - 1'b1;
   assign full    = (count_ff == CNT_FULL);

   ils_chain #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH),
      .IDX_W (IDX_W)
   ) u_chain (
      .clock    (clock),
      .ctrl     (cell_ctrl),
      .new_word (req_word),
      .rd_addr  (rd_addr),
      .rd_word  (rd_word)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      find_in      = find_ff;
      val_in       = val_ff;
      cell_ctrl    = '{op: CELL_HOLD, pos: '0};
      rd_addr      = IDX_W'(req_index);
      finish       = 1'b0;
      found        = 1'b0;
      status       = ST_OK;
      out_word     = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;

      if (state_ff == ST_IDLE) begin
         if (req_cmd == CMD_POP) begin
            rd_addr = IDX_W'(cnt_dec);
         end
         if (req_fire) begin
            finish = 1'b1;
            case (req_cmd)
               CMD_PUSH, CMD_PREPEND, CMD_INSERT: begin
                  if (req_cmd == CMD_INSERT && idx_ext > cnt_ext) begin
                     status = ST_RANGE;
                  end else if (full) begin
                     status = ST_FULL;
                  end else begin
                     cell_ctrl.op = CELL_INS;
                     if (req_cmd == CMD_PUSH) begin
                        cell_ctrl.pos = POS_W'(count_ff);
                     end else if (req_cmd == CMD_INSERT) begin
                        cell_ctrl.pos = POS_W'(req_index);
                     end
                     count_in = count_ff + 1'b1;
                  end
               end
               CMD_POP: begin
                  if (count_ff == '0) begin
                     status = ST_EMPTY;
                  end else begin
                     out_word = rd_word;
                     count_in = cnt_dec;
                  end
               end
               CMD_READ: begin
                  if (idx_ext >= cnt_ext) begin
                     status = ST_RANGE;
                  end else begin
                     out_word = rd_word;
                  end
               end
               CMD_DELETE: begin
                  if (idx_ext >= cnt_ext) begin
                     status = ST_RANGE;
                  end else begin
                     cell_ctrl.op  = CELL_DEL;
                     cell_ctrl.pos = POS_W'(req_index);
                     count_in      = cnt_dec;
                  end
               end
               default: begin
                  // Remove-all and find walk the list from position zero.
                  finish   = 1'b0;
                  state_in = ST_SCAN;
                  ptr_in   = '0;
                  find_in  = (req_cmd == CMD_FIND);
                  val_in   = req_word;
               end
            endcase
         end
      end else begin
         rd_addr = IDX_W'(ptr_ff);
         if (ptr_ff >= count_ff) begin
            finish = 1'b1;
         end else if (rd_word == val_ff) begin
            if (find_ff) begin
               finish = 1'b1;
               found  = 1'b1;
            end else begin
               // Drop the match; the next entry slides into this position.
               cell_ctrl.op  = CELL_DEL;
               cell_ctrl.pos = POS_W'(ptr_ff);
               count_in      = cnt_dec;
            end
         end else begin
            ptr_in = ptr_ff + 1'b1;
         end
         if (finish) begin
            state_in = ST_IDLE;
         end
      end

      if (finish) begin
         rsp_valid_in       = 1'b1;
         rsp_in.pad         = '0;
         rsp_in.data        = VALUE_W'(signed'(out_word));
         rsp_in.found       = found;
         rsp_in.found_index = found ? FIDX_W'(ptr_ff) : '0;
         rsp_in.status      = status;
         rsp_in.count       = COUNT_W'(count_in);
         rsp_in.empty_res   = (count_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         find_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         find_ff      <= find_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("entry count exceeds capacity");

   a_scan_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (!req_tready && !rsp_valid_ff))
      else $error("request accepted or result pending during a scan");

   a_scan_ptr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (ptr_ff <= count_ff))
      else $error("scan position passed the entry count");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.empty_res == (rsp_ff.count == '0)))
      else $error("empty flag disagrees with reported count");
`endif

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the indexed list store: edge cases, back pressure, random commands.
module tb;
   import ils_pkg::*;

   localparam int CLK_PERIOD  = 10;
   localparam int LIST_DEPTH  = DEPTH_DEFAULT;
   localparam int RANDOM_CMDS = 1280;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_WAIT  = 40;

   localparam logic [VALUE_W-1:0] MIN_WORD  = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] MAX_WORD  = 32'h7fff_ffff;
   localparam logic [VALUE_W-1:0] ALL_ONES  = 32'hffff_ffff;
   localparam logic [VALUE_W-1:0] FILL_WORD = 32'h0000_00a5;

   typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_BEAT} rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // index[4:0], value[36:5], zero pad
   logic [CMD_W-1:0]      req_tuser = CMD_PUSH;  // cmd[2:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // data, found, found_index, status, count, empty_res

   // Shadow copy of the list, updated as each command transaction is accepted.
   logic [VALUE_W-1:0] list_words [LIST_DEPTH];
   int                 list_count = 0;
   rsp_type            reply_q [$];
   logic [VALUE_W-1:0] word_pool [4];

   // Command mix, in percent, for a growing and a shrinking phase.
   logic [CMD_W-1:0] cmd_order [8] = '{CMD_PUSH, CMD_INSERT, CMD_PREPEND, CMD_POP,
                                       CMD_READ, CMD_DELETE, CMD_REMOVE, CMD_FIND};
   int grow_weight [8]   = '{25, 20, 13, 5, 12, 8, 5, 12};
   int shrink_weight [8] = '{8, 6, 4, 20, 12, 25, 10, 15};

   int          fail_count;
   int          cmds_sent;
   int          replies_seen;
   int          full_hits;
   int          status_seen [4];
   int          burst_left;
   bit          gaps_on = 1'b1;
   int          hold_requests;
   int          hold_served;
   int          hold_left;
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left;
   int          idle_cycles;

   indexed_list_store #(.DEPTH(LIST_DEPTH), .WIDTH(WIDTH_DEFAULT)) uut (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Applies one command to the shadow list and returns the result it must produce.
   function automatic rsp_type apply_list_cmd(input logic [CMD_W-1:0]   op,
                                              input logic [INDEX_W-1:0] pos,
                                              input logic [VALUE_W-1:0] word);
      rsp_type r;
      int      at;
      int      kept;
      int      i;
      r = '0;
      r.status = ST_OK;
      case (op)
         CMD_PUSH, CMD_INSERT, CMD_PREPEND: begin
            if (op == CMD_PUSH) begin
               at = list_count;
            end else if (op == CMD_PREPEND) begin
               at = 0;
            end else begin
               at = int'(pos);
            end
            // The index is checked before fullness.
            if (at > list_count) begin
               r.status = ST_RANGE;
            end else if (list_count >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (i = list_count; i > at; i--) list_words[i] = list_words[i - 1];
               list_words[at] = word;
               list_count++;
            end
         end
         CMD_POP: begin
            if (list_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               list_count--;
               r.data = list_words[list_count];
            end
         end
         CMD_READ: begin
            if (int'(pos) >= list_count) begin
               r.status = ST_RANGE;
            end else begin
               r.data = list_words[int'(pos)];
            end
         end
         CMD_DELETE: begin
            if (int'(pos) >= list_count) begin
               r.status = ST_RANGE;
            end else begin
               for (i = int'(pos); i < list_count - 1; i++) list_words[i] = list_words[i + 1];
               list_count--;
            end
         end
         CMD_REMOVE: begin
            kept = 0;
            for (i = 0; i < list_count; i++) begin
               if (list_words[i] != word) begin
                  list_words[kept] = list_words[i];
                  kept++;
               end
            end
            list_count = kept;
         end
         CMD_FIND: begin
            for (i = 0; i < list_count; i++) begin
               if (!r.found && list_words[i] == word) begin
                  r.found = 1'b1;
                  r.found_index = FIDX_W'(i);
               end
            end
         end
         default: begin
            r.status = ST_OK;
         end
      endcase
      r.count = COUNT_W'(list_count);
      r.empty_res = (list_count == 0);
      return r;
   endfunction

   function automatic void check_field(input string              name,
                                       input logic [VALUE_W-1:0] want,
                                       input logic [VALUE_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endfunction

   // Offers one command; the sender idles between bursts of random length.
   task automatic send_cmd(input logic [CMD_W-1:0]   op,
                           input logic [INDEX_W-1:0] pos,
                           input logic [VALUE_W-1:0] word);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = gaps_on ? $urandom_range(0, 7) : 0;
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, word, pos};
      do @(posedge clock); while (!req_tready);
      reply_q.push_back(apply_list_cmd(op, pos, word));
      cmds_sent++;
      if (list_count == LIST_DEPTH) full_hits++;
   endtask

   // Mostly meaningful commands (valid indexes, words already in the list), some noise.
   task automatic pick_random_cmd(input bit grow, output logic [CMD_W-1:0] op,
                                  output logic [INDEX_W-1:0] pos,
                                  output logic [VALUE_W-1:0] word);
      int roll;
      int acc;
      int k;
      int pick;
      if ($urandom_range(0, 99) < 8) begin
         op   = cmd_order[$urandom_range(0, 7)];
         pos  = INDEX_W'($urandom_range(0, 16));
         word = $urandom;
      end else begin
         roll = $urandom_range(0, 99);
         acc = 0;
         for (k = 0; k < 7; k++) begin
            acc += grow ? grow_weight[k] : shrink_weight[k];
            if (roll < acc) break;
         end
         op = cmd_order[k];
         if ($urandom_range(0, 6) == 0) begin
            pos = INDEX_W'($urandom_range(0, 16));
         end else if (op == CMD_INSERT) begin
            pos = INDEX_W'($urandom_range(0, list_count));
         end else begin
            pos = (list_count == 0) ? '0 : INDEX_W'($urandom_range(0, list_count - 1));
         end
         pick = $urandom_range(0, 9);
         if ((op == CMD_FIND || op == CMD_REMOVE) && list_count != 0 && pick < 6) begin
            word = list_words[$urandom_range(0, list_count - 1)];
         end else if (pick < 5) begin
            word = word_pool[$urandom_range(0, 3)];
         end else if (pick == 5) begin
            word = MIN_WORD;
         end else if (pick == 6) begin
            word = MAX_WORD;
         end else begin
            word = $urandom;
         end
      end
   endtask

   task automatic test_empty_list();
      send_cmd(CMD_POP, '0, '0);
      send_cmd(CMD_READ, 5'd16, '0);
      send_cmd(CMD_DELETE, '0, '0);
      send_cmd(CMD_FIND, '0, MIN_WORD);
      send_cmd(CMD_REMOVE, '0, '0);
      send_cmd(CMD_INSERT, 5'd1, MAX_WORD);
   endtask

   task automatic test_edit_ops();
      send_cmd(CMD_INSERT, '0, MIN_WORD);
      send_cmd(CMD_PUSH, 5'd16, MAX_WORD);
      send_cmd(CMD_PREPEND, 5'd16, ALL_ONES);
      send_cmd(CMD_INSERT, 5'd3, FILL_WORD);
      send_cmd(CMD_READ, 5'd1, '0);
      send_cmd(CMD_FIND, '0, MAX_WORD);
      send_cmd(CMD_DELETE, '0, '0);
   endtask

   task automatic test_full_list();
      while (list_count < LIST_DEPTH) send_cmd(CMD_PUSH, '0, FILL_WORD);
      send_cmd(CMD_PUSH, '0, MAX_WORD);
      send_cmd(CMD_INSERT, 5'd16, MAX_WORD);
      send_cmd(CMD_PREPEND, '0, MIN_WORD);
      // Compacts the two surviving entries out of a full row.
      send_cmd(CMD_REMOVE, '0, FILL_WORD);
      send_cmd(CMD_POP, '0, '0);
   endtask

   task automatic test_back_pressure();
      logic [CMD_W-1:0]   op;
      logic [INDEX_W-1:0] pos;
      logic [VALUE_W-1:0] word;
      int                 n;
      int                 k;
      for (k = 0; k < 4; k++) word_pool[k] = $urandom;
      gaps_on = 1'b0;
      hold_requests++;
      for (n = 0; n < 40; n++) begin
         pick_random_cmd(1'b1, op, pos, word);
         send_cmd(op, pos, word);
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_random_mix();
      logic [CMD_W-1:0]   op;
      logic [INDEX_W-1:0] pos;
      logic [VALUE_W-1:0] word;
      bit                 grow;
      int                 n;
      int                 k;
      grow = 1'b0;
      for (n = 0; n < RANDOM_CMDS; n++) begin
         if (n % 90 == 0) begin
            grow = ~grow;
            for (k = 0; k < 4; k++) word_pool[k] = $urandom;
         end
         pick_random_cmd(grow, op, pos, word);
         send_cmd(op, pos, word);
      end
   endtask

   // Receiver: a changing stall pattern, plus a long hold-off on request.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(16, 120);
      end else begin
         rx_left--;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            RX_BEAT:   rsp_tready <= rx_left[1];
            default:   rsp_tready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin : check_replies
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata);
         replies_seen++;
         status_seen[got.status]++;
         if (reply_q.size() == 0) begin
            $error("Result transaction with no command outstanding: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = reply_q.pop_front();
            check_field("data", want.data, got.data);
            check_field("found", want.found, got.found);
            check_field("found_index", want.found_index, got.found_index);
            check_field("status", want.status, got.status);
            check_field("count", want.count, got.count);
            check_field("empty_res", want.empty_res, got.empty_res);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                  idle_cycles, reply_q.size());
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_edit_ops();
      test_full_list();
      test_back_pressure();
      test_random_mix();
      req_tvalid <= 1'b0;
      while (reply_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("%0d commands sent, %0d results checked, %0d left the list full.",
               cmds_sent, replies_seen, full_hits);
      $display("Statuses seen: %0d ok, %0d out of range, %0d full, %0d empty; %0d mismatches.",
               status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL],
               status_seen[ST_EMPTY], fail_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
